>>> hw/rtl/dense_layer_train_engine_assert.svh
// Assertion macros shared by the checker of the dense layer engine.
// Depends on nothing; included by the checker file.
`ifndef DENSE_LAYER_TRAIN_ENGINE_ASSERT_SVH
`define DENSE_LAYER_TRAIN_ENGINE_ASSERT_SVH

// Implication checked in the same cycle, disabled while reset is asserted.
`define DLTE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication checked in the next cycle, disabled while reset is asserted.
`define DLTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/dlte_pkg.sv
// Types, constants and saturating Q16.16 helpers of the dense layer engine.
// Used by the front end, the back end, the top level and the checker.
package dlte_pkg;

  localparam int VW          = 32;
  localparam int FRAC        = 16;
  localparam int MAX_INPUTS  = 64;
  localparam int MAX_NEURONS = 32;
  localparam int XI_W        = $clog2(MAX_INPUTS);
  localparam int NI_W        = $clog2(MAX_NEURONS);
  localparam int WA_W        = NI_W + XI_W;
  localparam int CNT_IN_W    = 7;
  localparam int CNT_N_W     = 6;
  localparam int LR_W        = 17;
  localparam int RES_IDX_W   = 6;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;
  localparam int LEAK_SLOPE  = 655;

  typedef logic signed [VW-1:0] val_t;
  typedef logic signed [2*VW-1:0] prod_t;

  localparam val_t MAXV = {1'b0, {(VW-1){1'b1}}};
  localparam val_t MINV = {1'b1, {(VW-1){1'b0}}};

  typedef enum logic [2:0] {
    ACT_WR_W  = 3'd0,
    ACT_WR_B  = 3'd1,
    ACT_WR_X  = 3'd2,
    ACT_WR_E  = 3'd3,
    ACT_FWD   = 3'd4,
    ACT_BWD   = 3'd5,
    ACT_UPD   = 3'd6,
    ACT_NONE  = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    OP_WR_W, OP_WR_B, OP_WR_X, OP_WR_E, OP_FWD, OP_BWD, OP_RDERR, OP_UPD
  } op_t;

  localparam logic [1:0] MODE_BOTH = 2'd0;
  localparam logic [1:0] MODE_ERR  = 2'd1;
  localparam logic [1:0] MODE_GRAD = 2'd2;
  localparam logic [1:0] MODE_READ = 2'd3;

  localparam logic [1:0] AF_LIN  = 2'd0;
  localparam logic [1:0] AF_RELU = 2'd1;

  localparam logic [1:0] KIND_ACT  = 2'd0;
  localparam logic [1:0] KIND_IERR = 2'd1;
  localparam logic [1:0] KIND_MAX  = 2'd2;

  localparam logic [1:0] CFG_ACT = 2'd0;
  localparam logic [1:0] CFG_NIN = 2'd1;
  localparam logic [1:0] CFG_NN  = 2'd2;
  localparam logic [1:0] CFG_LR  = 2'd3;

  typedef struct packed {
    op_t             op;
    logic [NI_W-1:0] ni;
    logic [XI_W-1:0] ii;
    val_t            data;
    logic            do_err;
    logic            do_grad;
  } cmd_t;

  typedef struct packed {
    logic [1:0]          act_kind;
    logic [CNT_IN_W-1:0] nin;
    logic [CNT_N_W-1:0]  nn;
    logic [LR_W-1:0]     lr;
  } cfg_t;

  // Product shifted right by the fraction bits (floor), then saturated.
  function automatic val_t sat_q(input prod_t p);
    prod_t s;
    s = p >>> FRAC;
    if (!s[2*VW-1] && (|s[2*VW-2:VW-1])) return MAXV;
    if (s[2*VW-1] && !(&s[2*VW-2:VW-1])) return MINV;
    return s[VW-1:0];
  endfunction

  // Saturating add.
  function automatic val_t sadd(input val_t a, input val_t b);
    logic signed [VW:0] t;
    t = {a[VW-1], a} + {b[VW-1], b};
    if (t[VW] != t[VW-1]) return t[VW] ? MINV : MAXV;
    return t[VW-1:0];
  endfunction

  // Saturating magnitude.
  function automatic val_t sabs(input val_t v);
    if (v == MINV) return MAXV;
    return v[VW-1] ? -v : v;
  endfunction

endpackage

>>> hw/rtl/dlte_front.sv
// Front end of the dense layer engine: takes input items, decodes them into
// commands and holds them in a two-entry queue. Depends on dlte_pkg.
module dlte_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // neuron_index, input_index, data_value, backward_mode (lowest bit first)
  input  logic [dlte_pkg::IN_TDATA_W-1:0]  in_tdata,
  // action
  input  logic [2:0]                       in_tuser,
  input  logic                             clearing,
  output logic                             cmd_valid,
  input  logic                             cmd_ready,
  output dlte_pkg::cmd_t                   cmd
);
  import dlte_pkg::*;

  cmd_t       q_r [0:1];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  cmd_t       dec;
  logic       keep;
  logic       push, pop;
  logic [1:0] mode;

  // Decode the item into a command; the unused action code is dropped.
  always_comb begin
    mode        = in_tdata[44:43];
    dec.ni      = in_tdata[4:0];
    dec.ii      = in_tdata[10:5];
    dec.data    = in_tdata[42:11];
    dec.do_err  = (mode != MODE_GRAD);
    dec.do_grad = (mode != MODE_ERR);
    dec.op      = OP_WR_W;
    keep        = 1'b1;
    unique case (action_t'(in_tuser))
      ACT_WR_W: dec.op = OP_WR_W;
      ACT_WR_B: dec.op = OP_WR_B;
      ACT_WR_X: dec.op = OP_WR_X;
      ACT_WR_E: dec.op = OP_WR_E;
      ACT_FWD:  dec.op = OP_FWD;
      ACT_BWD:  dec.op = (mode == MODE_READ) ? OP_RDERR : OP_BWD;
      ACT_UPD:  dec.op = OP_UPD;
      default:  keep   = 1'b0;
    endcase
  end

  assign in_tready = (cnt_r != 2'd2) && !clearing;
  assign push      = in_tvalid && in_tready && keep;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_r[rp_r];

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= dec;
  end

endmodule

>>> hw/rtl/dlte_back.sv
// Back end of the dense layer engine: the layer memories, one shared
// multiplier, the pass sequencer and the result register. Depends on dlte_pkg.
module dlte_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  dlte_pkg::cmd_t                cmd,
  input  dlte_pkg::cfg_t                cfg,
  output logic                          clearing,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output dlte_pkg::val_t                out_value,
  output logic [dlte_pkg::RES_IDX_W-1:0] out_index,
  output logic [1:0]                    out_kind,
  output logic                          out_last
);
  import dlte_pkg::*;

  typedef enum logic [29:0] {
    S_CLEAR  = 30'd1 << 0,
    S_IDLE   = 30'd1 << 1,
    S_F_BRD  = 30'd1 << 2,
    S_F_BLD  = 30'd1 << 3,
    S_F_RD   = 30'd1 << 4,
    S_F_MUL  = 30'd1 << 5,
    S_F_ADD  = 30'd1 << 6,
    S_F_ACT  = 30'd1 << 7,
    S_F_LEAK = 30'd1 << 8,
    S_F_EMIT = 30'd1 << 9,
    S_R_RD   = 30'd1 << 10,
    S_R_EMIT = 30'd1 << 11,
    S_B_RD   = 30'd1 << 12,
    S_B_LD   = 30'd1 << 13,
    S_B_LEAK = 30'd1 << 14,
    S_B_GO   = 30'd1 << 15,
    S_B_BGRD = 30'd1 << 16,
    S_B_BGWR = 30'd1 << 17,
    S_B_IRD  = 30'd1 << 18,
    S_B_M1   = 30'd1 << 19,
    S_B_M2   = 30'd1 << 20,
    S_B_M3   = 30'd1 << 21,
    S_B_CLR  = 30'd1 << 22,
    S_U_RD   = 30'd1 << 23,
    S_U_MUL  = 30'd1 << 24,
    S_U_WR   = 30'd1 << 25,
    S_U_BRD  = 30'd1 << 26,
    S_U_BMUL = 30'd1 << 27,
    S_U_BWR  = 30'd1 << 28,
    S_U_EMIT = 30'd1 << 29
  } state_t;

  localparam int WDEPTH = 2**WA_W;

  state_t          state_r, state_nxt;
  logic [NI_W-1:0] n_r, n_nxt;
  logic [XI_W-1:0] i_r, i_nxt;
  logic [WA_W-1:0] clr_r, clr_nxt;
  val_t            acc_r, acc_nxt;
  val_t            e_r, e_nxt;
  val_t            best_r, best_nxt;
  logic            pass_r, pass_nxt;
  logic            do_err_r, do_err_nxt;
  logic            do_grad_r, do_grad_nxt;
  prod_t           prod_r;
  val_t            mul_a, mul_b;

  // Layer memories and their registered read data.
  val_t w_mem  [0:WDEPTH-1];
  val_t wg_mem [0:WDEPTH-1];
  val_t b_mem  [0:MAX_NEURONS-1];
  val_t bg_mem [0:MAX_NEURONS-1];
  val_t a_mem  [0:MAX_NEURONS-1];
  val_t e_mem  [0:MAX_NEURONS-1];
  val_t x_mem  [0:MAX_INPUTS-1];
  val_t ie_mem [0:MAX_INPUTS-1];
  val_t w_rd, wg_rd, b_rd, bg_rd, a_rd, e_rd, x_rd, ie_rd;

  logic            w_we, wg_we, b_we, bg_we, a_we, e_we, x_we, ie_we;
  logic [WA_W-1:0] w_wa, wg_wa;
  logic [NI_W-1:0] b_wa, bg_wa, a_wa, e_wa;
  logic [XI_W-1:0] x_wa, ie_wa;
  val_t            w_wd, wg_wd, b_wd, bg_wd, a_wd, e_wd, x_wd, ie_wd;

  logic [WA_W-1:0] wa_rd;
  logic            n_last, i_last, out_free, out_load;
  val_t            out_value_nxt, mag;
  logic [RES_IDX_W-1:0] out_index_nxt;
  logic [1:0]      out_kind_nxt;
  logic            out_last_nxt, out_valid_r;
  val_t            lr_val, leak_val;

  assign wa_rd     = {n_r, i_r};
  assign n_last    = ({1'b0, n_r} == (cfg.nn - CNT_N_W'(1)));
  assign i_last    = ({1'b0, i_r} == (cfg.nin - CNT_IN_W'(1)));
  assign out_free  = !out_valid_r || out_tready;
  assign cmd_ready = (state_r == S_IDLE);
  assign clearing  = (state_r == S_CLEAR);
  assign lr_val    = VW'(cfg.lr);
  assign leak_val  = VW'(LEAK_SLOPE);

  // Sequencer: next state, memory writes, multiplier operands and results.
  always_comb begin
    state_nxt   = state_r;
    n_nxt       = n_r;
    i_nxt       = i_r;
    clr_nxt     = clr_r;
    acc_nxt     = acc_r;
    e_nxt       = e_r;
    best_nxt    = best_r;
    pass_nxt    = pass_r;
    do_err_nxt  = do_err_r;
    do_grad_nxt = do_grad_r;
    mul_a       = '0;
    mul_b       = '0;
    w_we = 1'b0; wg_we = 1'b0; b_we = 1'b0; bg_we = 1'b0;
    a_we = 1'b0; e_we = 1'b0; x_we = 1'b0; ie_we = 1'b0;
    w_wa = wa_rd; wg_wa = wa_rd; b_wa = n_r; bg_wa = n_r;
    a_wa = n_r; e_wa = n_r; x_wa = i_r; ie_wa = i_r;
    w_wd = '0; wg_wd = '0; b_wd = '0; bg_wd = '0;
    a_wd = '0; e_wd = '0; x_wd = '0; ie_wd = '0;
    out_load      = 1'b0;
    out_value_nxt = acc_r;
    out_index_nxt = RES_IDX_W'(n_r);
    out_kind_nxt  = KIND_ACT;
    out_last_nxt  = n_last;
    mag           = '0;

    unique case (state_r)
      // Zero the stores that have a reset value, one word a cycle.
      S_CLEAR: begin
        wg_we = 1'b1; wg_wa = clr_r;
        bg_we = 1'b1; bg_wa = clr_r[NI_W-1:0];
        a_we  = 1'b1; a_wa  = clr_r[NI_W-1:0];
        e_we  = 1'b1; e_wa  = clr_r[NI_W-1:0];
        ie_we = 1'b1; ie_wa = clr_r[XI_W-1:0];
        clr_nxt = clr_r + WA_W'(1);
        if (clr_r == {WA_W{1'b1}}) state_nxt = S_IDLE;
      end

      // Take a command: writes finish here, passes start here.
      S_IDLE: begin
        if (cmd_valid) begin
          n_nxt = '0;
          i_nxt = '0;
          case (cmd.op)
            OP_WR_W: begin
              w_we = 1'b1; w_wa = {cmd.ni, cmd.ii}; w_wd = cmd.data;
            end
            OP_WR_B: begin
              b_we = 1'b1; b_wa = cmd.ni; b_wd = cmd.data;
            end
            OP_WR_X: begin
              x_we = 1'b1; x_wa = cmd.ii; x_wd = cmd.data;
            end
            OP_WR_E: begin
              e_we = 1'b1; e_wa = cmd.ni; e_wd = cmd.data;
            end
            OP_FWD: begin
              if (cfg.nn != '0) state_nxt = S_F_BRD;
            end
            OP_BWD: begin
              do_err_nxt  = cmd.do_err;
              do_grad_nxt = cmd.do_grad;
              if (cfg.nn != '0) state_nxt = S_B_RD;
            end
            OP_RDERR: begin
              if (cfg.nin != '0) state_nxt = S_R_RD;
            end
            OP_UPD: begin
              best_nxt = '0;
              if (cfg.nn == '0) state_nxt = S_U_EMIT;
              else if (cfg.nin == '0) state_nxt = S_U_BRD;
              else state_nxt = S_U_RD;
            end
            default: ;
          endcase
        end
      end

      // Forward pass.
      S_F_BRD: state_nxt = S_F_BLD;
      S_F_BLD: begin
        acc_nxt   = b_rd;
        i_nxt     = '0;
        state_nxt = (cfg.nin == '0) ? S_F_ACT : S_F_RD;
      end
      S_F_RD: state_nxt = S_F_MUL;
      S_F_MUL: begin
        mul_a = x_rd; mul_b = w_rd;
        state_nxt = S_F_ADD;
      end
      S_F_ADD: begin
        acc_nxt = sadd(acc_r, sat_q(prod_r));
        if (i_last) state_nxt = S_F_ACT;
        else begin
          i_nxt = i_r + XI_W'(1);
          state_nxt = S_F_RD;
        end
      end
      S_F_ACT: begin
        mul_a = acc_r; mul_b = leak_val;
        state_nxt = S_F_EMIT;
        if (acc_r[VW-1] || acc_r == '0) begin
          if (cfg.act_kind == AF_RELU) acc_nxt = '0;
          else if (cfg.act_kind != AF_LIN) state_nxt = S_F_LEAK;
        end
      end
      S_F_LEAK: begin
        acc_nxt   = sat_q(prod_r);
        state_nxt = S_F_EMIT;
      end
      S_F_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          a_we = 1'b1; a_wd = acc_r;
          if (n_last) state_nxt = S_IDLE;
          else begin
            n_nxt = n_r + NI_W'(1);
            state_nxt = S_F_BRD;
          end
        end
      end

      // Read out and clear the input errors.
      S_R_RD: state_nxt = S_R_EMIT;
      S_R_EMIT: begin
        out_value_nxt = ie_rd;
        out_index_nxt = RES_IDX_W'(i_r);
        out_kind_nxt  = KIND_IERR;
        out_last_nxt  = i_last;
        if (out_free) begin
          out_load = 1'b1;
          ie_we = 1'b1;
          if (i_last) state_nxt = S_IDLE;
          else begin
            i_nxt = i_r + XI_W'(1);
            state_nxt = S_R_RD;
          end
        end
      end

      // Backward pass: gate or scale the error by the stored activation.
      S_B_RD: state_nxt = S_B_LD;
      S_B_LD: begin
        mul_a = e_rd; mul_b = leak_val;
        e_nxt = e_rd;
        pass_nxt = (cfg.act_kind == AF_RELU) ? (!a_rd[VW-1] && a_rd != '0) : 1'b1;
        if (cfg.act_kind != AF_LIN && cfg.act_kind != AF_RELU && a_rd[VW-1])
          state_nxt = S_B_LEAK;
        else state_nxt = S_B_GO;
      end
      S_B_LEAK: begin
        e_nxt = sat_q(prod_r);
        state_nxt = S_B_GO;
      end
      S_B_GO: begin
        if (!pass_r) state_nxt = S_B_CLR;
        else if (do_grad_r) state_nxt = S_B_BGRD;
        else if (cfg.nin == '0) state_nxt = S_B_CLR;
        else state_nxt = S_B_IRD;
      end
      S_B_BGRD: state_nxt = S_B_BGWR;
      S_B_BGWR: begin
        bg_we = 1'b1; bg_wd = sadd(bg_rd, e_r);
        state_nxt = (cfg.nin == '0) ? S_B_CLR : S_B_IRD;
      end
      S_B_IRD: state_nxt = S_B_M1;
      S_B_M1: begin
        mul_a = e_r; mul_b = w_rd;
        state_nxt = S_B_M2;
      end
      S_B_M2: begin
        mul_a = e_r; mul_b = x_rd;
        ie_we = do_err_r; ie_wd = sadd(ie_rd, sat_q(prod_r));
        state_nxt = S_B_M3;
      end
      S_B_M3: begin
        wg_we = do_grad_r; wg_wd = sadd(wg_rd, sat_q(prod_r));
        if (i_last) state_nxt = S_B_CLR;
        else begin
          i_nxt = i_r + XI_W'(1);
          state_nxt = S_B_IRD;
        end
      end
      S_B_CLR: begin
        e_we = 1'b1;
        i_nxt = '0;
        if (n_last) state_nxt = S_IDLE;
        else begin
          n_nxt = n_r + NI_W'(1);
          state_nxt = S_B_RD;
        end
      end

      // Update pass: weights of one neuron, then its bias.
      S_U_RD: state_nxt = S_U_MUL;
      S_U_MUL: begin
        mul_a = wg_rd; mul_b = lr_val;
        mag = sabs(wg_rd);
        if (mag > best_r) best_nxt = mag;
        state_nxt = S_U_WR;
      end
      S_U_WR: begin
        w_we = 1'b1; w_wd = sadd(w_rd, sat_q(prod_r));
        wg_we = 1'b1;
        if (i_last) state_nxt = S_U_BRD;
        else begin
          i_nxt = i_r + XI_W'(1);
          state_nxt = S_U_RD;
        end
      end
      S_U_BRD: state_nxt = S_U_BMUL;
      S_U_BMUL: begin
        mul_a = bg_rd; mul_b = lr_val;
        mag = sabs(bg_rd);
        if (mag > best_r) best_nxt = mag;
        state_nxt = S_U_BWR;
      end
      S_U_BWR: begin
        b_we = 1'b1; b_wd = sadd(b_rd, sat_q(prod_r));
        bg_we = 1'b1;
        i_nxt = '0;
        if (n_last) state_nxt = S_U_EMIT;
        else begin
          n_nxt = n_r + NI_W'(1);
          state_nxt = (cfg.nin == '0) ? S_U_BRD : S_U_RD;
        end
      end
      S_U_EMIT: begin
        out_value_nxt = best_r;
        out_index_nxt = '0;
        out_kind_nxt  = KIND_MAX;
        out_last_nxt  = 1'b1;
        if (out_free) begin
          out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // Datapath registers and the shared multiplier.
  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    i_r       <= i_nxt;
    acc_r     <= acc_nxt;
    e_r       <= e_nxt;
    best_r    <= best_nxt;
    pass_r    <= pass_nxt;
    do_err_r  <= do_err_nxt;
    do_grad_r <= do_grad_nxt;
    prod_r    <= (2*VW)'(mul_a) * (2*VW)'(mul_b);
    if (out_load) begin
      out_value <= out_value_nxt;
      out_index <= out_index_nxt;
      out_kind  <= out_kind_nxt;
      out_last  <= out_last_nxt;
    end
  end

  // Memories: one write port and one registered read port each.
  always_ff @(posedge clk) begin
    if (w_we)  w_mem[w_wa]   <= w_wd;
    if (wg_we) wg_mem[wg_wa] <= wg_wd;
    if (b_we)  b_mem[b_wa]   <= b_wd;
    if (bg_we) bg_mem[bg_wa] <= bg_wd;
    if (a_we)  a_mem[a_wa]   <= a_wd;
    if (e_we)  e_mem[e_wa]   <= e_wd;
    if (x_we)  x_mem[x_wa]   <= x_wd;
    if (ie_we) ie_mem[ie_wa] <= ie_wd;
    w_rd  <= w_mem[wa_rd];
    wg_rd <= wg_mem[wa_rd];
    b_rd  <= b_mem[n_r];
    bg_rd <= bg_mem[n_r];
    a_rd  <= a_mem[n_r];
    e_rd  <= e_mem[n_r];
    x_rd  <= x_mem[i_r];
    ie_rd <= ie_mem[i_r];
  end

  assign out_tvalid = out_valid_r;

endmodule

>>> hw/rtl/dense_layer_train_engine.sv
// Top level of the dense layer training engine: configuration registers and
// the front and back ends. Depends on dlte_pkg, dlte_front and dlte_back.
//
// One fully connected layer in signed Q16.16 with saturating arithmetic.
// After reset the engine zeroes its gradient, activation and error memories
// and takes no item then. One multiply-accumulate runs at a time on a
// single multiplier fed from memories with one read port each. The neuron
// and input counts in use are at most 32 and 64. A two-entry command
// queue lets items arrive while a pass runs, and a result register lets the
// engine continue while a result waits.
module dense_layer_train_engine (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // neuron_index, input_index, data_value, backward_mode (lowest bit first)
  input  logic [dlte_pkg::IN_TDATA_W-1:0]    in_tdata,
  // action
  input  logic [2:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // result_value, result_index (lowest bit first)
  output logic [dlte_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // result_kind
  output logic [1:0]                         out_tuser,
  output logic                               out_tlast,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [dlte_pkg::LR_W-1:0]          cfg_wdata
);
  import dlte_pkg::*;

  logic [1:0]          act_kind_r;
  logic [CNT_IN_W-1:0] input_count_r;
  logic [CNT_N_W-1:0]  neuron_count_r;
  logic [LR_W-1:0]     learning_rate_r;
  cfg_t                cfg;
  cmd_t                cmd;
  logic                cmd_valid, cmd_ready, clearing;
  val_t                out_value;
  logic [RES_IDX_W-1:0] out_index;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_kind_r      <= 2'd2;
      input_count_r   <= CNT_IN_W'(64);
      neuron_count_r  <= CNT_N_W'(32);
      learning_rate_r <= LR_W'(655);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ACT: act_kind_r      <= cfg_wdata[1:0];
        CFG_NIN: input_count_r   <= cfg_wdata[CNT_IN_W-1:0];
        CFG_NN:  neuron_count_r  <= cfg_wdata[CNT_N_W-1:0];
        CFG_LR:  learning_rate_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Counts beyond the store sizes use the whole store.
  always_comb begin
    cfg.act_kind = act_kind_r;
    cfg.nin = (input_count_r > CNT_IN_W'(MAX_INPUTS)) ? CNT_IN_W'(MAX_INPUTS) : input_count_r;
    cfg.nn  = (neuron_count_r > CNT_N_W'(MAX_NEURONS)) ? CNT_N_W'(MAX_NEURONS)
                                                       : neuron_count_r;
    cfg.lr  = learning_rate_r;
  end

  dlte_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .clearing  (clearing),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  dlte_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .cfg        (cfg),
    .clearing   (clearing),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_value  (out_value),
    .out_index  (out_index),
    .out_kind   (out_tuser),
    .out_last   (out_tlast)
  );

  assign out_tdata = {2'b00, out_index, out_value};

endmodule

>>> hw/rtl/dlte_checker.sv
// Port-level checker of the dense layer engine and its bind statement.
// Depends on dlte_pkg and dense_layer_train_engine_assert.svh.
`include "dense_layer_train_engine_assert.svh"

module dlte_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [dlte_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic [2:0]                       in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [dlte_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [1:0]                       out_tuser,
  input logic                             out_tlast,
  input logic                             cfg_we,
  input logic [1:0]                       cfg_index,
  input logic [dlte_pkg::LR_W-1:0]        cfg_wdata
);
  import dlte_pkg::*;

  // A waiting result holds still.
  `DLTE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // The update result is a single item at index zero.
  `DLTE_ASSERT_IMPL(a_upd_single, clk, rst_n, out_tvalid && out_tuser == KIND_MAX, out_tlast && out_tdata[37:32] == 6'd0)

  // The memory clearing pass after reset blocks input items.
  `DLTE_ASSERT_IMPL(a_clear_block, clk, rst_n, $rose(rst_n), !in_tready)

endmodule

bind dense_layer_train_engine dlte_checker u_dlte_checker (.*);

>>> tb/sv/dense_layer_train_engine_checker.sv
// Scoreboard for the dense layer training engine: predicts every result from the
// items and register writes it sees, and compares the results. Depends on dlte_pkg.
`timescale 1ns / 100ps

module dense_layer_train_engine_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [dlte_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [2:0]                       in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [dlte_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic [1:0]                       out_tuser,
  input  logic                             out_tlast,
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_index,
  input  logic [dlte_pkg::LR_W-1:0]        cfg_wdata,
  output int                               fail_count,
  output int                               pending
);
  import dlte_pkg::*;

  typedef struct {
    val_t       value;
    logic [5:0] idx;
    logic [1:0] kind;
    logic       last;
  } layer_result_t;

  layer_result_t result_q[$];

  // Shadow copy of the layer state and its registers.
  val_t weight_m [MAX_NEURONS*MAX_INPUTS];
  val_t wgrad_m  [MAX_NEURONS*MAX_INPUTS];
  val_t bias_m   [MAX_NEURONS];
  val_t bgrad_m  [MAX_NEURONS];
  val_t xact_m   [MAX_INPUTS];
  val_t yact_m   [MAX_NEURONS];
  val_t oerr_m   [MAX_NEURONS];
  val_t ierr_m   [MAX_INPUTS];
  logic [1:0]          act_sel;
  logic [CNT_IN_W-1:0] nin_reg;
  logic [CNT_N_W-1:0]  nn_reg;
  logic [LR_W-1:0]     lr_reg;
  int errors;

  function automatic val_t clamp32(longint v);
    if (v > longint'(MAXV)) return MAXV;
    if (v < longint'(MINV)) return MINV;
    return val_t'(v);
  endfunction

  // Exact product, floor shift by the fraction bits, then saturate.
  function automatic val_t fx_mul(val_t a, longint b);
    longint p;
    p = longint'(a) * b;
    return clamp32(p >>> FRAC);
  endfunction

  function automatic val_t fx_add(val_t a, val_t b);
    return clamp32(longint'(a) + longint'(b));
  endfunction

  function automatic val_t fx_mag(val_t v);
    if (v == MINV) return MAXV;
    return (v < 0) ? -v : v;
  endfunction

  function automatic bit is_leaky();
    return act_sel != AF_LIN && act_sel != AF_RELU;
  endfunction

  // Appends one expected result at the tail of the queue.
  function automatic void queue_result(layer_result_t r);
    result_q.insert(result_q.size(), r);
  endfunction

  // Runs one command on the shadow state and queues the results it causes.
  task automatic run_command(action_t act, int ni, int ii, val_t data, logic [1:0] mode);
    int nn, nin, w;
    val_t s, e, best;
    bit pass, do_err, do_grad;
    nn  = (nn_reg > MAX_NEURONS) ? MAX_NEURONS : nn_reg;
    nin = (nin_reg > MAX_INPUTS) ? MAX_INPUTS : nin_reg;
    case (act)
      ACT_WR_W: weight_m[ni*MAX_INPUTS + ii] = data;
      ACT_WR_B: bias_m[ni] = data;
      ACT_WR_X: xact_m[ii] = data;
      ACT_WR_E: oerr_m[ni] = data;
      ACT_FWD: begin
        for (int n = 0; n < nn; n++) begin
          s = bias_m[n];
          for (int i = 0; i < nin; i++)
            s = fx_add(s, fx_mul(xact_m[i], longint'(weight_m[n*MAX_INPUTS + i])));
          if (s <= 0) begin
            if (act_sel == AF_RELU) s = '0;
            else if (is_leaky()) s = fx_mul(s, LEAK_SLOPE);
          end
          yact_m[n] = s;
          queue_result('{s, n[5:0], KIND_ACT, n == nn - 1});
        end
      end
      ACT_BWD: begin
        if (mode == MODE_READ) begin
          for (int i = 0; i < nin; i++) begin
            queue_result('{ierr_m[i], i[5:0], KIND_IERR, i == nin - 1});
            ierr_m[i] = '0;
          end
        end else begin
          do_err  = mode != MODE_GRAD;
          do_grad = mode != MODE_ERR;
          for (int n = 0; n < nn; n++) begin
            e = oerr_m[n];
            pass = 1'b1;
            if (act_sel == AF_RELU) pass = yact_m[n] > 0;
            else if (is_leaky() && yact_m[n] < 0) e = fx_mul(e, LEAK_SLOPE);
            if (pass) begin
              for (int i = 0; i < nin; i++) begin
                w = n*MAX_INPUTS + i;
                if (do_err)  ierr_m[i] = fx_add(ierr_m[i], fx_mul(e, longint'(weight_m[w])));
                if (do_grad) wgrad_m[w] = fx_add(wgrad_m[w], fx_mul(e, longint'(xact_m[i])));
              end
              if (do_grad) bgrad_m[n] = fx_add(bgrad_m[n], e);
            end
            oerr_m[n] = '0;
          end
        end
      end
      ACT_UPD: begin
        best = '0;
        for (int n = 0; n < nn; n++) begin
          for (int i = 0; i < nin; i++) begin
            w = n*MAX_INPUTS + i;
            if (fx_mag(wgrad_m[w]) > best) best = fx_mag(wgrad_m[w]);
            weight_m[w] = fx_add(weight_m[w], fx_mul(wgrad_m[w], longint'(lr_reg)));
            wgrad_m[w] = '0;
          end
          if (fx_mag(bgrad_m[n]) > best) best = fx_mag(bgrad_m[n]);
          bias_m[n] = fx_add(bias_m[n], fx_mul(bgrad_m[n], longint'(lr_reg)));
          bgrad_m[n] = '0;
        end
        queue_result('{best, 6'd0, KIND_MAX, 1'b1});
      end
      default: ;
    endcase
  endtask

  task automatic report(string what, longint exp_v, longint act_v);
    errors++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    layer_result_t head;
    if (!rst_n) begin
      act_sel = 2'd2;
      nin_reg = 7'd64;
      nn_reg  = 6'd32;
      lr_reg  = 17'd655;
      foreach (weight_m[k]) begin
        weight_m[k] = '0;
        wgrad_m[k]  = '0;
      end
      foreach (bias_m[k]) begin
        bias_m[k] = '0; bgrad_m[k] = '0; yact_m[k] = '0; oerr_m[k] = '0;
      end
      foreach (xact_m[k]) begin
        xact_m[k] = '0;
        ierr_m[k] = '0;
      end
      result_q.delete();
      errors = 0;
    end else begin
      // Results are checked before new items are predicted.
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected no result, actual value %0d",
                   $time, $signed(out_tdata[31:0]));
        end else begin
          head = result_q.pop_front();
          if ($signed(out_tdata[31:0]) != head.value)
            report("value", head.value, $signed(out_tdata[31:0]));
          if (out_tdata[37:32] != head.idx) report("index", head.idx, out_tdata[37:32]);
          if (out_tuser != head.kind)       report("kind", head.kind, out_tuser);
          if (out_tlast != head.last)       report("last", head.last, out_tlast);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_ACT: act_sel = cfg_wdata[1:0];
          CFG_NIN: nin_reg = cfg_wdata[CNT_IN_W-1:0];
          CFG_NN:  nn_reg  = cfg_wdata[CNT_N_W-1:0];
          CFG_LR:  lr_reg  = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        run_command(action_t'(in_tuser), in_tdata[4:0], in_tdata[10:5],
                    val_t'(in_tdata[42:11]), in_tdata[44:43]);
    end
    fail_count <= errors;
    pending    <= result_q.size();
  end

endmodule

>>> tb/sv/tb.sv
// Testbench top for the dense layer training engine: drives commands and register
// writes with random idling. Depends on dlte_pkg, the engine and its checker.
`timescale 1ns / 100ps

module tb;
  import dlte_pkg::*;

  localparam int WATCHDOG_LIMIT = 100000;
  localparam int NUM_PHASES = 7;

  // Register settings per phase, including out-of-range and zero counts.
  localparam logic [1:0] ACT_TAB [NUM_PHASES] = '{2'd2, 2'd1, 2'd0, 2'd3, 2'd2, 2'd1, 2'd0};
  localparam int NIN_TAB [NUM_PHASES]   = '{3, 64, 0, 127, 1, 7, 4};
  localparam int NN_TAB [NUM_PHASES]    = '{2, 1, 32, 1, 63, 0, 3};
  localparam int LR_TAB [NUM_PHASES]    = '{655, 65536, 0, 131071, 1000, 20000, 30000};
  localparam int COUNT_TAB [NUM_PHASES] = '{0, 15, 10, 15, 10, 10, 10};

  logic clk, rst_n;
  logic in_tvalid, in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;
  logic [2:0] in_tuser;
  logic out_tvalid, out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0] out_tuser;
  logic out_tlast;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [LR_W-1:0] cfg_wdata;
  int fail_count, pending;
  logic hold_off;
  int idle_cycles;

  // Entries of the stores that have been written at least once.
  bit weight_set [MAX_NEURONS*MAX_INPUTS];
  bit bias_set [MAX_NEURONS];
  bit input_set [MAX_INPUTS];
  int burst_left;

  dense_layer_train_engine dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  dense_layer_train_engine_checker checker_i (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .cfg_we, .cfg_index, .cfg_wdata, .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver switches among always ready, mostly ready and mostly stalled.
  int stall_mode, stall_cnt;
  always @(posedge clk) begin
    if (stall_cnt == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_cnt  <= $urandom_range(16, 96);
    end else begin
      stall_cnt <= stall_cnt - 1;
    end
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || hold_off || (in_tvalid && in_tready) || (out_tvalid && out_tready)
        || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic val_t pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return val_t'($urandom_range(0, 524288)) - val_t'(262144);
    if (r < 85) return val_t'($urandom);
    if (r < 90) return MAXV;
    if (r < 95) return MINV;
    return $urandom_range(0, 1) ? val_t'(0) : val_t'(-1);
  endfunction

  // Sends one item in bursts with random gaps; valid stays high within a burst.
  task automatic send_item(action_t act, int ni, int ii, val_t data, logic [1:0] mode);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {3'b000, mode, data, ii[5:0], ni[4:0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    case (act)
      ACT_WR_W: weight_set[ni*MAX_INPUTS + ii] = 1'b1;
      ACT_WR_B: bias_set[ni] = 1'b1;
      ACT_WR_X: input_set[ii] = 1'b1;
      default: ;
    endcase
  endtask

  // Waits for every expected result, then lets any silent pass finish.
  task automatic drain(int nn, int nin);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    hold_off <= 1'b1;
    repeat (3 * (nn * (4 * nin + 7) + 2 * nin) + 200) @(posedge clk);
    hold_off <= 1'b0;
  endtask

  task automatic write_regs(logic [1:0] act, int nin, int nn, int lr);
    logic [LR_W-1:0] vals [4];
    vals = '{act, nin, nn, lr};
    for (int k = 0; k < 4; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= k[1:0];
      cfg_wdata <= vals[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25)      send_item(ACT_WR_W, $urandom_range(0, 31), $urandom_range(0, 63),
                               pick_value(), $urandom_range(0, 3));
    else if (r < 33) send_item(ACT_WR_B, $urandom_range(0, 31), $urandom_range(0, 63),
                               pick_value(), $urandom_range(0, 3));
    else if (r < 45) send_item(ACT_WR_X, $urandom_range(0, 31), $urandom_range(0, 63),
                               pick_value(), $urandom_range(0, 3));
    else if (r < 60) send_item(ACT_WR_E, $urandom_range(0, 31), $urandom_range(0, 63),
                               pick_value(), $urandom_range(0, 3));
    else if (r < 72) send_item(ACT_FWD, $urandom_range(0, 31), $urandom_range(0, 63),
                               val_t'($urandom), $urandom_range(0, 3));
    else if (r < 90) send_item(ACT_BWD, $urandom_range(0, 31), $urandom_range(0, 63),
                               val_t'($urandom), $urandom_range(0, 3));
    else if (r < 97) send_item(ACT_UPD, $urandom_range(0, 31), $urandom_range(0, 63),
                               val_t'($urandom), $urandom_range(0, 3));
    else             send_item(ACT_NONE, $urandom_range(0, 31), $urandom_range(0, 63),
                               val_t'($urandom), $urandom_range(0, 3));
  endtask

  // Short directed sequence: saturating products, every pass and backward mode,
  // extreme addresses, the unused action code and clearing of cleared stores.
  task automatic directed_items();
    send_item(ACT_WR_W, 0, 0, MAXV, MODE_BOTH);
    send_item(ACT_WR_W, 0, 1, MINV, MODE_BOTH);
    send_item(ACT_WR_X, 0, 0, MAXV, MODE_BOTH);
    send_item(ACT_WR_X, 0, 1, MINV, MODE_BOTH);
    send_item(ACT_WR_X, 31, 63, val_t'(-65536), MODE_READ);
    send_item(ACT_WR_W, 31, 63, val_t'(12345), MODE_READ);
    send_item(ACT_WR_B, 1, 0, val_t'(-300000), MODE_BOTH);
    send_item(ACT_FWD, 0, 0, '0, MODE_BOTH);
    send_item(ACT_WR_E, 0, 0, MAXV, MODE_BOTH);
    send_item(ACT_WR_E, 1, 0, MINV, MODE_BOTH);
    send_item(ACT_BWD, 0, 0, '0, MODE_BOTH);
    send_item(ACT_BWD, 0, 0, '0, MODE_READ);
    send_item(ACT_WR_E, 0, 0, val_t'(70000), MODE_BOTH);
    send_item(ACT_WR_E, 1, 0, val_t'(-70000), MODE_BOTH);
    send_item(ACT_BWD, 0, 0, '0, MODE_ERR);
    send_item(ACT_WR_E, 1, 0, MINV, MODE_BOTH);
    send_item(ACT_BWD, 0, 0, '0, MODE_GRAD);
    send_item(ACT_UPD, 0, 0, '0, MODE_BOTH);
    send_item(ACT_NONE, 31, 63, MAXV, MODE_READ);
    send_item(ACT_FWD, 0, 0, '0, MODE_BOTH);
    send_item(ACT_UPD, 0, 0, '0, MODE_BOTH);
    send_item(ACT_BWD, 0, 0, '0, MODE_READ);
  endtask

  initial begin
    int nn_use, nin_use;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= '0;
    cfg_wdata  <= '0;
    hold_off   <= 1'b0;
    out_tready <= 1'b0;
    stall_cnt  = 0;
    stall_mode = 0;
    burst_left = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    nn_use = 32;
    nin_use = 64;
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_regs(ACT_TAB[p], NIN_TAB[p], NN_TAB[p], LR_TAB[p]);
      nn_use  = (NN_TAB[p] > MAX_NEURONS) ? MAX_NEURONS : NN_TAB[p];
      nin_use = (NIN_TAB[p] > MAX_INPUTS) ? MAX_INPUTS : NIN_TAB[p];
      // Every entry a pass may read gets written first.
      for (int n = 0; n < nn_use; n++) begin
        if (!bias_set[n]) send_item(ACT_WR_B, n, 0, pick_value(), MODE_BOTH);
        for (int i = 0; i < nin_use; i++)
          if (!weight_set[n*MAX_INPUTS + i])
            send_item(ACT_WR_W, n, i, pick_value(), MODE_BOTH);
      end
      for (int i = 0; i < nin_use; i++)
        if (!input_set[i]) send_item(ACT_WR_X, 0, i, pick_value(), MODE_BOTH);
      if (p == 0) directed_items();
      for (int k = 0; k < COUNT_TAB[p]; k++) random_item();
      drain(nn_use, nin_use);
    end
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/dlte_pkg.sv
hw/rtl/dlte_front.sv
hw/rtl/dlte_back.sv
hw/rtl/dense_layer_train_engine.sv
hw/rtl/dlte_checker.sv
tb/sv/dense_layer_train_engine_checker.sv
tb/sv/tb.sv
